FILE: design/bsm_pkg.sv
package bsm_pkg;

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    localparam int DEPTH_W = 16;
    localparam int IDX_OUT_W = 10;
    localparam int POS_OUT_W = 24;
    localparam int LVL_OUT_W = 6;

    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam logic [2:0] ADDR_ENABLE = 3'd0;

    typedef struct packed {
        logic push;
        logic pop;
    } bsm_shift_t;

    typedef struct packed {
        logic                 overflow;
        logic                 kind;
        logic [LVL_OUT_W-1:0] level;
        logic [POS_OUT_W-1:0] position;
        logic [IDX_OUT_W-1:0] scope_index;
    } bsm_result_t;

endpackage

FILE: design/brace_scope_matcher_top.sv
// brace scope matcher
// input stream: one text byte per transfer, tdata = ch, tuser = first (starts a new
// pass: position, scope count and depth cleared before the byte is handled)
// output stream: at most one transfer per input byte; an opening brace reports its
// scope index, start position and level, a matched closing brace reports the scope
// it closes and its end position; overflow marks a brace beyond the scope or stack
// capacity
// apb port: register 0 at address 0 is enable (reset 1); while low, input transfers
// are taken and ignored
// each result is registered in the output buffer before it appears on the output
// throughput: one byte per cycle while s_axis_tready is high; the open-scope stack is
// a row of MAX_DEPTH cells that all shift by one position on a push or pop in the same cycle
// stall: a two-entry output buffer keeps input flowing while one result waits;
// s_axis_tready drops only once both entries hold results
// reset: output buffer empty, counters zero, enable high; stack cells are not
// cleared since a pass reads only entries it has pushed
module brace_scope_matcher_top
    import bsm_pkg::*;
#(
    parameter int MAX_SCOPES    = 1024,
    parameter int MAX_DEPTH     = 64,
    parameter int POSITION_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // scope_index[9:0], position[33:10], level[39:34]
    output logic [1:0]  m_axis_tuser,   // kind[0], overflow[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_SCOPES + 1);
    localparam logic [CNT_W-1:0]   SCOPE_LIM = CNT_W'(MAX_SCOPES);
    localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    logic                     enable_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [DEPTH_W-1:0]       depth_reg;
    logic [DEPTH_W-1:0]       depth_next;

    logic                     s_accept;
    logic                     work;
    logic [POSITION_BITS-1:0] pos_eff;
    logic [CNT_W-1:0]         cnt_eff;
    logic [DEPTH_W-1:0]       d_eff;
    logic [DEPTH_W-1:0]       d_dec;
    logic                     is_open;
    logic                     is_close;
    logic                     fits;
    bsm_shift_t               shift;
    logic                     res_valid;
    bsm_result_t              res;
    bsm_result_t              out;

    logic [CNT_W-1:0]         cell_idx [MAX_DEPTH];
    logic                     cell_vld [MAX_DEPTH];

    logic [CNT_W-1:0]         idx_sel;
    logic [CNT_W+IDX_OUT_W-1:0]         idx_wide;
    logic [POSITION_BITS+POS_OUT_W-1:0] pos_wide;

    // configuration
    assign pready = 1'b1;
    assign prdata = {31'b0, enable_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && (paddr[2] == ADDR_ENABLE[2]))
        begin
            enable_reg <= pwdata[0];
        end
    end

    // per-byte decode
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign work     = s_accept && enable_reg;
    assign pos_eff  = s_axis_tuser ? '0 : pos_reg;
    assign cnt_eff  = s_axis_tuser ? '0 : cnt_reg;
    assign d_eff    = s_axis_tuser ? '0 : depth_reg;
    assign d_dec    = d_eff - DEPTH_W'(1);
    assign is_open  = (s_axis_tdata == OPEN_BRACE);
    assign is_close = (s_axis_tdata == CLOSE_BRACE) && (d_eff != '0);
    assign fits     = (cnt_eff < SCOPE_LIM) && (d_eff < DEPTH_LIM);

    assign shift = {work && is_open && (d_eff < DEPTH_LIM),
                    work && is_close && (d_dec < DEPTH_LIM)};

    assign pos_wide = {{POS_OUT_W{1'b0}}, pos_eff};

    always_comb
    begin
        idx_sel       = '0;
        res.overflow  = 1'b0;
        res.kind      = KIND_OPEN;
        res.level     = d_eff[LVL_OUT_W-1:0];
        if (is_open)
        begin
            idx_sel      = fits ? cnt_eff : '0;
            res.overflow = !fits;
        end
        else
        begin
            res.kind  = KIND_CLOSE;
            res.level = d_dec[LVL_OUT_W-1:0];
            if ((d_dec < DEPTH_LIM) && cell_vld[0])
            begin
                idx_sel = cell_idx[0];
            end
            else
            begin
                res.overflow = 1'b1;
            end
        end
        idx_wide        = {{IDX_OUT_W{1'b0}}, idx_sel};
        res.scope_index = idx_wide[IDX_OUT_W-1:0];
        res.position    = pos_wide[POS_OUT_W-1:0];
    end

    assign res_valid       = work && (is_open || is_close);

    always_comb
    begin
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        if (work)
        begin
            pos_next   = pos_eff + POSITION_BITS'(1);
            cnt_next   = cnt_eff;
            depth_next = d_eff;
            if (is_open)
            begin
                if (fits)
                begin
                    cnt_next = cnt_eff + CNT_W'(1);
                end
                if (d_eff != DEPTH_SAT)
                begin
                    depth_next = d_eff + DEPTH_W'(1);
                end
            end
            else if (is_close)
            begin
                depth_next = d_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cnt_reg   <= '0;
            depth_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
        end
    end

    // open-scope stack, cell 0 is the top
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEPTH; gi++)
        begin : g_cell
            logic [CNT_W-1:0] a_idx;
            logic             a_vld;
            logic [CNT_W-1:0] b_idx;
            logic             b_vld;

            if (gi == 0)
            begin : g_top
                assign a_idx = cnt_eff;
                assign a_vld = fits;
            end
            else
            begin : g_mid
                assign a_idx = cell_idx[gi-1];
                assign a_vld = cell_vld[gi-1];
            end

            if (gi == MAX_DEPTH - 1)
            begin : g_bot
                assign b_idx = cell_idx[gi];
                assign b_vld = cell_vld[gi];
            end
            else
            begin : g_nbot
                assign b_idx = cell_idx[gi+1];
                assign b_vld = cell_vld[gi+1];
            end

            bsm_cell #(
                .IDX_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .shift     (shift),
                .above_idx (a_idx),
                .above_vld (a_vld),
                .below_idx (b_idx),
                .below_vld (b_vld),
                .idx       (cell_idx[gi]),
                .vld       (cell_vld[gi])
            );
        end
    endgenerate

    bsm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out       (out)
    );

    assign m_axis_tdata = {out.level, out.position, out.scope_index};
    assign m_axis_tuser = {out.overflow, out.kind};

    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SCOPE_LIM)
        else $error("scope count above capacity");

    a_recorded_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.overflow) |-> ((is_open && d_eff < DEPTH_LIM)
            || (is_close && d_dec < DEPTH_LIM)))
        else $error("recorded scope outside stack range");

    a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !enable_reg) |=> ($stable(depth_reg) && $stable(cnt_reg)
            && $stable(pos_reg)))
        else $error("state changed while disabled");

endmodule

FILE: design/bsm_cell.sv
module bsm_cell
    import bsm_pkg::*;
#(
    parameter int IDX_W = 11
)
(
    input  logic             clk,
    input  bsm_shift_t       shift,
    input  logic [IDX_W-1:0] above_idx,
    input  logic             above_vld,
    input  logic [IDX_W-1:0] below_idx,
    input  logic             below_vld,
    output logic [IDX_W-1:0] idx,
    output logic             vld
);

    logic [IDX_W-1:0] idx_reg;
    logic             vld_reg;
    logic [IDX_W-1:0] idx_next;
    logic             vld_next;

    always_comb
    begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (shift.push)
        begin
            idx_next = above_idx;
            vld_next = above_vld;
        end
        else if (shift.pop)
        begin
            idx_next = below_idx;
            vld_next = below_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        vld_reg <= vld_next;
    end

    assign idx = idx_reg;
    assign vld = vld_reg;

endmodule

FILE: design/bsm_out_buf.sv
module bsm_out_buf
    import bsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  bsm_result_t res,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output bsm_result_t out
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    bsm_result_t out_reg;
    bsm_result_t out_next;
    bsm_result_t skid_reg;
    bsm_result_t skid_next;
    logic        pop;

    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

FILE: dv/brace_scope_checker.sv
module brace_scope_checker
    import bsm_pkg::*;
#(
    parameter int MAX_SCOPES = 1024,
    parameter int MAX_DEPTH  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tuser,   // first
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // scope_index, position, level
    input  logic [1:0]  m_axis_tuser,   // kind, overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                    track_on;
    logic [POS_OUT_W-1:0]    byte_pos;
    logic [10:0]             scope_cnt;
    logic [DEPTH_W-1:0]      depth;
    logic [10:0]             open_idx [MAX_DEPTH];
    logic                    open_ok  [MAX_DEPTH];
    bsm_result_t             scope_events_due [$];

    function automatic bit track_brace(input logic [7:0] c, input logic f,
                                       output bsm_result_t evt);
        logic [DEPTH_W-1:0] d;
        bit                 emitted;
        emitted = 1'b0;
        evt = '0;
        if (track_on)
        begin
            if (f)
            begin
                byte_pos  = '0;
                scope_cnt = '0;
                depth     = '0;
            end
            d = depth;
            if (c == OPEN_BRACE)
            begin
                evt.kind     = KIND_OPEN;
                evt.position = byte_pos;
                evt.level    = d[LVL_OUT_W-1:0];
                if (scope_cnt < MAX_SCOPES && d < MAX_DEPTH)
                begin
                    open_idx[d]     = scope_cnt;
                    open_ok[d]      = 1'b1;
                    evt.scope_index = scope_cnt[IDX_OUT_W-1:0];
                    scope_cnt       = scope_cnt + 1'b1;
                end
                else
                begin
                    if (d < MAX_DEPTH)
                        open_ok[d] = 1'b0;
                    evt.overflow = 1'b1;
                end
                emitted = 1'b1;
                if (depth != {DEPTH_W{1'b1}})
                    depth = depth + 1'b1;
            end
            else if (c == CLOSE_BRACE && depth != '0)
            begin
                depth = depth - 1'b1;
                d = depth;
                evt.kind     = KIND_CLOSE;
                evt.position = byte_pos;
                evt.level    = d[LVL_OUT_W-1:0];
                if (d < MAX_DEPTH && open_ok[d])
                    evt.scope_index = open_idx[d][IDX_OUT_W-1:0];
                else
                    evt.overflow = 1'b1;
                emitted = 1'b1;
            end
            byte_pos = byte_pos + 1'b1;
        end
        return emitted;
    endfunction

    task automatic flag_field(input string name, input logic [23:0] want,
                              input logic [23:0] seen);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bsm_result_t seen;
        bsm_result_t due;
        bsm_result_t next_evt;
        if (!rst_n)
        begin
            track_on  = 1'b1;
            byte_pos  = '0;
            scope_cnt = '0;
            depth     = '0;
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                open_idx[i] = '0;
                open_ok[i]  = 1'b0;
            end
            scope_events_due.delete();
            errors = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = bsm_result_t'({m_axis_tuser, m_axis_tdata});
                if (scope_events_due.size() == 0)
                begin
                    $display("%0t: unexpected scope event, expected none, got kind %0d %s %0d",
                             $time, seen.kind, "index", seen.scope_index);
                    errors++;
                end
                else
                begin
                    due = scope_events_due.pop_front();
                    if (seen.kind !== due.kind)
                        flag_field("kind", due.kind, seen.kind);
                    if (seen.scope_index !== due.scope_index)
                        flag_field("scope_index", due.scope_index, seen.scope_index);
                    if (seen.position !== due.position)
                        flag_field("position", due.position, seen.position);
                    if (seen.level !== due.level)
                        flag_field("level", due.level, seen.level);
                    if (seen.overflow !== due.overflow)
                        flag_field("overflow", due.overflow, seen.overflow);
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE)
                track_on = pwdata[0];
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (track_brace(s_axis_tdata, s_axis_tuser, next_evt))
                    scope_events_due.push_back(next_evt);
            end
        end
        pending = scope_events_due.size();
    end

endmodule

FILE: dv/tb_brace_scope_matcher_top.sv
module tb_brace_scope_matcher_top;
    import bsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SCOPES    = 1024;
    localparam int MAX_DEPTH     = 64;
    localparam int POSITION_BITS = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_BYTES  = 1450;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // ch
    logic        s_axis_tuser;   // first
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // scope_index[9:0], position[33:10], level[39:34]
    logic [1:0]  m_axis_tuser;   // kind[0], overflow[1]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int errors;
    int bytes_in;
    int results_out;
    int tracked_bytes;
    int passes;
    int cfg_writes;
    int holds_done;
    bit enable_now;
    bit tx_steady;
    bit rx_steady;
    bit rx_hold;

    brace_scope_matcher_top #(
        .MAX_SCOPES    (MAX_SCOPES),
        .MAX_DEPTH     (MAX_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    brace_scope_checker #(
        .MAX_SCOPES (MAX_SCOPES),
        .MAX_DEPTH  (MAX_DEPTH)
    ) scope_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .pending       (pending),
        .errors        (errors)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_byte(input bit deep);
        int r;
        r = $urandom_range(0, 99);
        if (r < (deep ? 72 : 30))
            return OPEN_BRACE;
        if (r < (deep ? 87 : 58))
            return CLOSE_BRACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send(input logic [7:0] c, input logic f);
        int gap;
        gap = idle_len(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= f;
        do @(posedge clk); while (!s_axis_tready);
        if (enable_now)
            tracked_bytes++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_enable(input bit on);
        logic [31:0] v;
        v = $urandom;
        v[0] = on;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENABLE;
        pwdata  <= v;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        enable_now = on;
        cfg_writes++;
    endtask

    task automatic run_pass(input int len, input bit deep);
        send(pick_byte(deep), 1'b1);
        for (int i = 1; i < len; i++)
            send(pick_byte(deep), $urandom_range(0, 99) == 0);
        passes++;
    endtask

    // output side backpressure
    initial
    begin
        int gap_left;
        gap_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                gap_left = HOLD_CYCLES;
                holds_done++;
            end
            if (gap_left > 0)
            begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                gap_left = idle_len(rx_steady);
            end
        end
    end

    // watchdog on cycles with no transfer on either stream
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready)
                bytes_in++;
            if (m_axis_tvalid && m_axis_tready)
                results_out++;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_brace_scope_matcher_top: FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        int target;
        int done;
        int len;
        int random_start;
        bit on;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        enable_now = 1'b1;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset state, unmatched close, byte extremes, nesting
        send(OPEN_BRACE, 1'b0);
        send("x", 1'b0);
        send(CLOSE_BRACE, 1'b0);
        send(CLOSE_BRACE, 1'b0);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h7A, 1'b0);
        send(8'h7C, 1'b0);
        send(8'h7E, 1'b0);
        send(OPEN_BRACE, 1'b1);
        send(OPEN_BRACE, 1'b0);
        send(OPEN_BRACE, 1'b0);
        send(CLOSE_BRACE, 1'b0);
        // tracking off: everything ignored, state kept
        drain();
        set_enable(1'b0);
        send(OPEN_BRACE, 1'b1);
        send(CLOSE_BRACE, 1'b0);
        send(8'hFF, 1'b1);
        drain();
        set_enable(1'b1);
        send(CLOSE_BRACE, 1'b0);
        send(CLOSE_BRACE, 1'b0);
        send(CLOSE_BRACE, 1'b0);
        send(CLOSE_BRACE, 1'b1);
        send(OPEN_BRACE, 1'b1);
        drain();

        // stack too deep
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < MAX_DEPTH + 6; i++)
            send(OPEN_BRACE, i == 0);
        for (int i = 0; i < MAX_DEPTH + 6; i++)
            send(CLOSE_BRACE, 1'b0);
        drain();

        random_start = tracked_bytes;
        phase = 0;
        while (tracked_bytes - random_start < RANDOM_BYTES)
        begin
            drain();
            on = (phase % 6 != 4);
            set_enable(on);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                rx_hold = 1'b1;
                tx_steady = 1'b1;
            end
            if (!on)
            begin
                for (int i = 0; i < 20; i++)
                    send(pick_byte(1'b0), $urandom_range(0, 1));
            end
            else
            begin
                target = $urandom_range(60, 200);
                done = 0;
                while (done < target)
                begin
                    len = $urandom_range(8, 100);
                    run_pass(len, $urandom_range(0, 5) == 0);
                    done += len;
                end
            end
            phase++;
        end
        drain();
        set_enable(1'b1);
        repeat (10) @(negedge clk);

        $display("run covered %0d byte transfers, %0d scope events, %0d random passes",
                 bytes_in, results_out, passes);
        $display("%0d enable writes, %0d long output stalls, deep stack overflow",
                 cfg_writes, holds_done);
        if (errors == 0)
            $display("tb_brace_scope_matcher_top: PASS");
        else
            $display("tb_brace_scope_matcher_top: FAIL");
        $finish;
    end

endmodule
